FILE: sv/hlsd_pkg.sv
// ----------------------------------------------------------------------------
// hlsd_pkg
// Constants shared by the hexagonal lattice snap and dedupe block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hlsd_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 31;
    localparam int CFG_IDX_W  = 3;

    localparam logic [31:0] SIN60_Q32 = 32'd3719550787;

    localparam logic [CFG_IDX_W-1:0] REG_PITCH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_MARGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MARGIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_H    = 3'd5;

endpackage

`default_nettype wire

FILE: sv/hex_lattice_snap_dedupe_core.sv
// ----------------------------------------------------------------------------
// hex_lattice_snap_dedupe_core
// Snaps dots to a hexagonal lattice, drops near duplicates and border dots.
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        sink       in_valid, in_ready, first_point, x_in, y_in
// out       source     out_valid, out_ready, x_out, y_out, store_overflow
// cfg       sink       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Each item scans the N dots stored in the set (up to 1024) before the next
// accept; a duplicate hit ends the scan early.
// The shared bit-serial divider runs 63 steps twice; the store is scanned one
// entry per cycle through its registered read port.
// in_ready is high only while idle; a kept dot waits at its output step while
// the previous result is still held.
// Reset clears the count and flag; store contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hex_lattice_snap_dedupe_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   first_point,
    input  wire logic [hlsd_pkg::COORD_W-1:0]           x_in,
    input  wire logic [hlsd_pkg::COORD_W-1:0]           y_in,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [31:0]                          x_out,
    output logic signed [31:0]                          y_out,
    output logic                                        store_overflow,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [hlsd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [hlsd_pkg::COORD_W-1:0]           cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_HS, S_DIVR, S_DIVC, S_MA, S_MB, S_MY, S_SX, S_CMP, S_STORE, S_OUT
    } state_t;

    state_t state_reg;

    logic [30:0] pitch_reg, tol_reg, xm_reg, ym_reg, aw_reg, ah_reg;
    logic [30:0] x_reg, y_reg, h_reg, hs_reg;
    logic [30:0] div_rem_reg, div_d_reg;
    logic [62:0] div_num_reg;
    logic [5:0]  div_cnt_reg;
    logic [62:0] rowq_reg;
    logic [63:0] colq_reg;
    logic [62:0] a_reg;
    logic [61:0] b_reg;
    logic signed [31:0] sx_reg, sy_reg;
    logic [hlsd_pkg::CNT_W-1:0] count_reg, rd_idx_reg;
    logic ovf_reg, cmp_vld_reg, dup_reg;
    logic signed [31:0] rd_x_reg, rd_y_reg;

    logic signed [31:0] mem_x [hlsd_pkg::MAX_POINTS];
    logic signed [31:0] mem_y [hlsd_pkg::MAX_POINTS];

    // divider step
    logic [31:0] div_t;
    logic        div_ge;
    logic [31:0] div_sub;
    logic [30:0] div_rem_next;
    logic [62:0] div_num_next;

    assign div_t        = {div_rem_reg, div_num_reg[62]};
    assign div_ge       = div_t >= {1'b0, div_d_reg};
    assign div_sub      = div_t - {1'b0, div_d_reg};
    assign div_rem_next = div_ge ? div_sub[30:0] : div_t[30:0];
    assign div_num_next = {div_num_reg[61:0], div_ge};

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] hs_rnd;
    logic [30:0] hs_calc;

    always_comb
    begin
        case (state_reg)
            S_HS:
            begin
                mul_a = {1'b0, h_reg};
                mul_b = hlsd_pkg::SIN60_Q32;
            end
            S_MA:
            begin
                mul_a = colq_reg[63:32];
                mul_b = {1'b0, h_reg};
            end
            S_MB:
            begin
                mul_a = {1'b0, rowq_reg[62:32]};
                mul_b = {1'b0, h_reg};
            end
            S_MY:
            begin
                mul_a = {1'b0, rowq_reg[62:32]};
                mul_b = {1'b0, hs_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign hs_rnd  = mul_p + 64'h0000_0000_8000_0000;
    assign hs_calc = (hs_rnd[62:32] == '0) ? 31'd1 : hs_rnd[62:32];

    // snapped x with saturation
    logic [62:0] b_inc;
    logic signed [64:0] sx_diff;
    logic signed [31:0] sx_calc;

    assign b_inc   = {1'b0, b_reg} + 63'd1;
    assign sx_diff = $signed({2'b00, a_reg}) - $signed({3'b000, b_inc[62:1]});

    always_comb
    begin
        if (sx_diff > 65'sd2147483647)
        begin
            sx_calc = 32'sh7FFF_FFFF;
        end
        else if (sx_diff < -65'sd2147483648)
        begin
            sx_calc = 32'sh8000_0000;
        end
        else
        begin
            sx_calc = sx_diff[31:0];
        end
    end

    // store compare
    logic signed [32:0] dx, dy;
    logic [32:0] adx, ady;
    logic        hit;

    assign dx  = {sx_reg[31], sx_reg} - {rd_x_reg[31], rd_x_reg};
    assign dy  = {sy_reg[31], sy_reg} - {rd_y_reg[31], rd_y_reg};
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);
    assign hit = cmp_vld_reg && (adx < {2'b00, tol_reg}) && (ady < {2'b00, tol_reg});

    logic rd_en, wr_en, room;
    assign room  = count_reg < hlsd_pkg::CNT_W'(hlsd_pkg::MAX_POINTS);
    assign rd_en = (state_reg == S_CMP) && !hit && (rd_idx_reg < count_reg);
    assign wr_en = (state_reg == S_STORE) && room;

    // border test
    logic signed [32:0] sx_e, sy_e, x_lim, y_lim;
    logic keep;

    assign sx_e  = {sx_reg[31], sx_reg};
    assign sy_e  = {sy_reg[31], sy_reg};
    assign x_lim = $signed({2'b00, aw_reg}) - $signed({2'b00, xm_reg});
    assign y_lim = $signed({2'b00, ah_reg}) - $signed({2'b00, ym_reg});
    assign keep  = !dup_reg
                && !(sx_e < $signed({2'b00, xm_reg})) && !(sx_e > x_lim)
                && !(sy_e < $signed({2'b00, ym_reg})) && !(sy_e > y_lim);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[count_reg[hlsd_pkg::ADDR_W-1:0]] <= sx_reg;
            mem_y[count_reg[hlsd_pkg::ADDR_W-1:0]] <= sy_reg;
        end
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_idx_reg[hlsd_pkg::ADDR_W-1:0]];
            rd_y_reg <= mem_y[rd_idx_reg[hlsd_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= 31'd65536;
            tol_reg   <= 31'd66;
            xm_reg    <= '0;
            ym_reg    <= '0;
            aw_reg    <= 31'h7FFF_FFFF;
            ah_reg    <= 31'h7FFF_FFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hlsd_pkg::REG_PITCH:     pitch_reg <= cfg_data;
                hlsd_pkg::REG_TOLERANCE: tol_reg   <= cfg_data;
                hlsd_pkg::REG_X_MARGIN:  xm_reg    <= cfg_data;
                hlsd_pkg::REG_Y_MARGIN:  ym_reg    <= cfg_data;
                hlsd_pkg::REG_AREA_W:    aw_reg    <= cfg_data;
                hlsd_pkg::REG_AREA_H:    ah_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            out_valid      <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            dup_reg        <= 1'b0;
            rd_idx_reg     <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (out_valid && out_ready && !((state_reg == S_OUT) && keep))
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg <= x_in;
                        y_reg <= y_in;
                        h_reg <= (pitch_reg == '0) ? 31'd1 : pitch_reg;
                        if (first_point)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                        state_reg <= S_HS;
                    end
                end
                S_HS:
                begin
                    hs_reg      <= hs_calc;
                    div_d_reg   <= hs_calc;
                    div_rem_reg <= '0;
                    div_num_reg <= {y_reg, 32'd0};
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIVR;
                end
                S_DIVR:
                begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd62)
                    begin
                        rowq_reg    <= div_num_next;
                        div_d_reg   <= h_reg;
                        div_rem_reg <= '0;
                        div_num_reg <= {x_reg, 32'd0};
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIVC;
                    end
                    else
                    begin
                        div_rem_reg <= div_rem_next;
                        div_num_reg <= div_num_next;
                    end
                end
                S_DIVC:
                begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd62)
                    begin
                        colq_reg  <= {1'b0, div_num_next} + {2'b00, rowq_reg[62:1]};
                        state_reg <= S_MA;
                    end
                    else
                    begin
                        div_rem_reg <= div_rem_next;
                        div_num_reg <= div_num_next;
                    end
                end
                S_MA:
                begin
                    a_reg     <= mul_p[62:0];
                    state_reg <= S_MB;
                end
                S_MB:
                begin
                    b_reg     <= mul_p[61:0];
                    state_reg <= S_MY;
                end
                S_MY:
                begin
                    sy_reg    <= {1'b0, mul_p[30:0]};
                    state_reg <= S_SX;
                end
                S_SX:
                begin
                    sx_reg      <= sx_calc;
                    rd_idx_reg  <= '0;
                    cmp_vld_reg <= 1'b0;
                    dup_reg     <= 1'b0;
                    state_reg   <= S_CMP;
                end
                S_CMP:
                begin
                    if (hit)
                    begin
                        dup_reg     <= 1'b1;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= S_STORE;
                    end
                    else if (rd_en)
                    begin
                        rd_idx_reg  <= rd_idx_reg + hlsd_pkg::CNT_W'(1);
                        cmp_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= S_STORE;
                    end
                end
                S_STORE:
                begin
                    if (room)
                    begin
                        count_reg <= count_reg + hlsd_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!keep)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!out_valid || out_ready)
                    begin
                        out_valid      <= 1'b1;
                        x_out          <= sx_reg;
                        y_out          <= sy_reg;
                        store_overflow <= ovf_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hlsd_pkg::CNT_W'(hlsd_pkg::MAX_POINTS))
        else $error("store count beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == hlsd_pkg::CNT_W'(hlsd_pkg::MAX_POINTS)))
        else $error("overflow flag set with room in store");

    a_sy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (sy_reg <= $signed({1'b0, y_reg})))
        else $error("snapped y above input y");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (rd_idx_reg <= count_reg))
        else $error("scan index past stored count");
`endif

endmodule

`default_nettype wire
